@@ sv/sirac_pkg.sv @@
package sirac_pkg;

	localparam int VALUE_BITS = 32;
	localparam int RADIX_BITS = 6;
	localparam int CHAR_BITS  = 8;
	localparam int DIGIT_BITS = 6;
	localparam int STEP_BITS  = $clog2(VALUE_BITS);
	localparam int DEPTH      = VALUE_BITS;
	localparam int COUNT_BITS = $clog2(DEPTH + 1);
	localparam int MSG_LEN    = 15;
	localparam int MSG_BITS   = $clog2(MSG_LEN);

	localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
	localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(36);
	localparam logic [DIGIT_BITS-1:0] DIGIT_LIMIT = DIGIT_BITS'(10);

	localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_BITS-1:0] CH_LOWA  = 8'h61;
	localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2d;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [RADIX_BITS-1:0] radix_t;
	typedef logic [DIGIT_BITS-1:0] digit_t;
	typedef logic [CHAR_BITS-1:0]  char_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [MSG_BITS-1:0]   msg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_DIGIT,
		ST_BAD
	} state_t;

	typedef struct packed {
		logic start;
		value_t dividend;
		radix_t divisor;
	} div_ctl_t;

	typedef struct packed {
		logic push;
		logic pop;
		digit_t digit;
	} stack_ctl_t;

	function automatic char_t digit_char(digit_t d);
		char_t c;
		if (d < DIGIT_LIMIT) begin
			c = CH_ZERO + char_t'(d);
		end else begin
			c = CH_LOWA + char_t'(d - DIGIT_LIMIT);
		end
		return c;
	endfunction

	function automatic char_t bad_char(msg_idx_t i);
		char_t c;
		case (i)
			4'd0:    c = 8'h28;
			4'd1:    c = 8'h69;
			4'd2:    c = 8'h6e;
			4'd3:    c = 8'h76;
			4'd4:    c = 8'h61;
			4'd5:    c = 8'h6c;
			4'd6:    c = 8'h69;
			4'd7:    c = 8'h64;
			4'd8:    c = 8'h20;
			4'd9:    c = 8'h72;
			4'd10:   c = 8'h61;
			4'd11:   c = 8'h64;
			4'd12:   c = 8'h69;
			4'd13:   c = 8'h78;
			4'd14:   c = 8'h29;
			default: c = 8'h29;
		endcase
		return c;
	endfunction

endpackage

@@ sv/sirac_divider.sv @@
module sirac_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  sirac_pkg::div_ctl_t ctl,
	output logic                done,
	output sirac_pkg::value_t   quot,
	output sirac_pkg::digit_t   rem
);

	localparam logic [sirac_pkg::STEP_BITS-1:0] LAST_STEP =
		sirac_pkg::STEP_BITS'(sirac_pkg::VALUE_BITS - 1);

	sirac_pkg::value_t   q_q;
	sirac_pkg::digit_t   rem_q;
	sirac_pkg::radix_t   div_q;
	logic [sirac_pkg::STEP_BITS-1:0] step_q;
	logic                run_q;
	logic                done_q;

	logic [sirac_pkg::DIGIT_BITS:0] trial;
	logic [sirac_pkg::DIGIT_BITS:0] diff;
	logic                           fits;

	always_comb begin
		trial = {rem_q, q_q[sirac_pkg::VALUE_BITS-1]};
		diff  = trial - {1'b0, div_q};
		fits  = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (ctl.start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (run_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == LAST_STEP) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			q_q   <= ctl.dividend;
			rem_q <= '0;
			div_q <= ctl.divisor;
		end else if (run_q) begin
			q_q   <= {q_q[sirac_pkg::VALUE_BITS-2:0], fits};
			rem_q <= fits ? diff[sirac_pkg::DIGIT_BITS-1:0] : trial[sirac_pkg::DIGIT_BITS-1:0];
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign rem  = rem_q;

endmodule

@@ sv/sirac_digit_stack.sv @@
module sirac_digit_stack (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sirac_pkg::stack_ctl_t ctl,
	output sirac_pkg::digit_t     top,
	output sirac_pkg::count_t     count
);

	sirac_pkg::digit_t entry_q [sirac_pkg::DEPTH];
	sirac_pkg::count_t count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.push) begin
			count_q <= count_q + 1'b1;
		end else if (ctl.pop) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q[0] <= ctl.digit;
			for (int i = 1; i < sirac_pkg::DEPTH; i++) begin
				entry_q[i] <= entry_q[i-1];
			end
		end else if (ctl.pop) begin
			for (int i = 0; i < sirac_pkg::DEPTH - 1; i++) begin
				entry_q[i] <= entry_q[i+1];
			end
		end
	end

	assign top   = entry_q[0];
	assign count = count_q;

endmodule

@@ sv/signed_int_to_radix_ascii_unit.sv @@
// Signed integer to ASCII text in a radix of 2 to 36.
// Request channel: value and radix, accepted when req_valid is high and
// req_stall is low. req_stall stays high from an accepted item until its
// final character is loaded, so one item is worked on at a time.
// Text channel: char_code, last, bad_radix, one character per item, most
// significant digit first, a leading '-' for negative values, last set on
// the final character. A radix outside 2..36 gives "(invalid radix)" with
// bad_radix set, one character per cycle after acceptance while txt_stall is low.
// Conversion: each digit comes from a bit-serial restoring divider; its
// remainder is pushed on the digit stack and its quotient is divided
// again until it is zero. The digits then leave one per cycle from the
// digit stack while txt_stall is low, and the next request can be taken
// in the cycle after the final character is loaded.
// A high txt_stall holds a valid output and the emitter; nothing is
// lost. A new request is taken while the final character still waits.
// Reset clears the state machine, the output valid and the stack count.
module signed_int_to_radix_ascii_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic signed [sirac_pkg::VALUE_BITS-1:0] value,
	input  sirac_pkg::radix_t       radix,
	output logic                    txt_valid,
	input  logic                    txt_stall,
	output sirac_pkg::char_t        char_code,
	output logic                    last,
	output logic                    bad_radix
);

	localparam sirac_pkg::msg_idx_t MSG_LAST = sirac_pkg::MSG_BITS'(sirac_pkg::MSG_LEN - 1);

	sirac_pkg::state_t     state_q, state_d;
	sirac_pkg::radix_t     radix_q;
	logic                  neg_q;
	sirac_pkg::msg_idx_t   idx_q;
	logic                  txt_valid_q;
	sirac_pkg::char_t      char_q;
	logic                  last_q;
	logic                  bad_q;

	sirac_pkg::div_ctl_t   div_ctl;
	logic                  div_done;
	sirac_pkg::value_t     div_quot;
	sirac_pkg::digit_t     div_rem;
	sirac_pkg::stack_ctl_t stk_ctl;
	sirac_pkg::digit_t     stk_top;
	sirac_pkg::count_t     stk_count;

	logic                  accept;
	logic                  radix_ok;
	logic                  out_free;
	logic                  quot_zero;
	sirac_pkg::value_t     mag;
	logic                  load_out;
	sirac_pkg::char_t      char_d;
	logic                  last_d;
	logic                  bad_d;

	sirac_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	sirac_digit_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (stk_ctl),
		.top    (stk_top),
		.count  (stk_count)
	);

	assign req_stall = state_q != sirac_pkg::ST_IDLE;
	assign accept    = req_valid && !req_stall;
	assign radix_ok  = radix >= sirac_pkg::RADIX_MIN && radix <= sirac_pkg::RADIX_MAX;
	assign out_free  = !txt_valid_q || !txt_stall;
	assign quot_zero = div_quot == '0;
	assign mag       = value[sirac_pkg::VALUE_BITS-1] ? (~value + 1'b1) : value;

	always_comb begin
		state_d = state_q;
		case (state_q)
			sirac_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = radix_ok ? sirac_pkg::ST_DIV : sirac_pkg::ST_BAD;
				end
			end
			sirac_pkg::ST_DIV: begin
				if (div_done && quot_zero) begin
					state_d = neg_q ? sirac_pkg::ST_SIGN : sirac_pkg::ST_DIGIT;
				end
			end
			sirac_pkg::ST_SIGN: begin
				if (out_free) begin
					state_d = sirac_pkg::ST_DIGIT;
				end
			end
			sirac_pkg::ST_DIGIT: begin
				if (out_free && stk_count == sirac_pkg::COUNT_BITS'(1)) begin
					state_d = sirac_pkg::ST_IDLE;
				end
			end
			sirac_pkg::ST_BAD: begin
				if (out_free && idx_q == MSG_LAST) begin
					state_d = sirac_pkg::ST_IDLE;
				end
			end
			default: state_d = sirac_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		div_ctl.start    = 1'b0;
		div_ctl.dividend = div_quot;
		div_ctl.divisor  = radix_q;
		stk_ctl.push     = 1'b0;
		stk_ctl.pop      = 1'b0;
		stk_ctl.digit    = div_rem;
		load_out         = 1'b0;
		char_d           = sirac_pkg::digit_char(stk_top);
		last_d           = 1'b0;
		bad_d            = 1'b0;
		case (state_q)
			sirac_pkg::ST_IDLE: begin
				div_ctl.start    = accept && radix_ok;
				div_ctl.dividend = mag;
				div_ctl.divisor  = radix;
			end
			sirac_pkg::ST_DIV: begin
				stk_ctl.push  = div_done;
				div_ctl.start = div_done && !quot_zero;
			end
			sirac_pkg::ST_SIGN: begin
				load_out = out_free;
				char_d   = sirac_pkg::CH_MINUS;
			end
			sirac_pkg::ST_DIGIT: begin
				load_out    = out_free;
				stk_ctl.pop = out_free;
				last_d      = stk_count == sirac_pkg::COUNT_BITS'(1);
			end
			sirac_pkg::ST_BAD: begin
				load_out = out_free;
				char_d   = sirac_pkg::bad_char(idx_q);
				last_d   = idx_q == MSG_LAST;
				bad_d    = 1'b1;
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sirac_pkg::ST_IDLE;
			txt_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				txt_valid_q <= 1'b1;
			end else if (!txt_stall) begin
				txt_valid_q <= 1'b0;
			end
			if (accept) begin
				idx_q <= '0;
			end else if (state_q == sirac_pkg::ST_BAD && out_free) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			radix_q <= radix;
			neg_q   <= value[sirac_pkg::VALUE_BITS-1];
		end
		if (load_out) begin
			char_q <= char_d;
			last_q <= last_d;
			bad_q  <= bad_d;
		end
	end

	assign txt_valid = txt_valid_q;
	assign char_code = char_q;
	assign last      = last_q;
	assign bad_radix = bad_q;

endmodule

@@ test/tb_signed_int_to_radix_ascii_unit.sv @@
`timescale 1ns / 1ps

module tb_signed_int_to_radix_ascii_unit;
	import sirac_pkg::*;

	localparam int           CLK_HALF     = 6;
	localparam int           RESET_CYCLES = 10;
	localparam int           SETTLE_CYCLES = 1200;
	localparam int unsigned  CYCLE_LIMIT  = 1500000;
	localparam int           SHOWN_ERRORS = 10;
	localparam string        BAD_TEXT     = "(invalid radix)";

	typedef struct {
		char_t code;
		logic  fin;
		logic  bad;
	} text_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	value_t      value = '0;
	radix_t      radix = '0;
	logic        txt_valid;
	logic        txt_stall = 1'b0;
	char_t       char_code;
	logic        last;
	logic        bad_radix;

	text_char_t  pending_chars[$];
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	signed_int_to_radix_ascii_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.value     (value),
		.radix     (radix),
		.txt_valid (txt_valid),
		.txt_stall (txt_stall),
		.char_code (char_code),
		.last      (last),
		.bad_radix (bad_radix)
	);

	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		txt_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	function automatic char_t numeral(int unsigned d);
		char_t c;
		if (d < DIGIT_LIMIT) begin
			c = CH_ZERO + char_t'(d);
		end else begin
			c = CH_LOWA + char_t'(d - DIGIT_LIMIT);
		end
		return c;
	endfunction

	// queue the text that one value and radix should produce
	function automatic void spell_value(value_t v, radix_t r);
		char_t  digits[$];
		value_t mag;
		logic   neg;
		int     i;
		if (r < RADIX_MIN || r > RADIX_MAX) begin
			for (i = 0; i < MSG_LEN; i++) begin
				pending_chars.push_back('{BAD_TEXT[i], i == MSG_LEN - 1, 1'b1});
			end
			return;
		end
		neg = v[VALUE_BITS-1];
		mag = neg ? -v : v;
		do begin
			digits.push_front(numeral(int'(mag % r)));
			mag = mag / r;
		end while (mag != 0);
		if (neg) begin
			pending_chars.push_back('{CH_MINUS, 1'b0, 1'b0});
		end
		for (i = 0; i < digits.size(); i++) begin
			pending_chars.push_back('{digits[i], i == digits.size() - 1, 1'b0});
		end
	endfunction

	always @(posedge clk) begin
		text_char_t exp_c;
		if (arst_n && txt_valid && !txt_stall) begin
			if (pending_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_ERRORS) begin
					$display("unexpected item: char %h last %b bad %b",
						char_code, last, bad_radix);
				end
			end else begin
				exp_c = pending_chars.pop_front();
				if (char_code !== exp_c.code || last !== exp_c.fin ||
						bad_radix !== exp_c.bad) begin
					mismatches++;
					if (mismatches <= SHOWN_ERRORS) begin
						$display("expected char %h last %b bad %b, got char %h last %b bad %b",
							exp_c.code, exp_c.fin, exp_c.bad, char_code, last, bad_radix);
					end
				end
			end
		end
	end

	task automatic send_item(value_t v, radix_t r);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		value     <= v;
		radix     <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		spell_value(v, r);
	endtask

	task automatic hold_until_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	function automatic value_t pick_value();
		value_t v;
		case ($urandom_range(4))
			0: v = $urandom;
			1: v = value_t'($urandom_range(40));
			2: begin
				case ($urandom_range(4))
					0: v = 32'h8000_0000;
					1: v = 32'h7fff_ffff;
					2: v = 32'hffff_ffff;
					3: v = 32'h0000_0001;
					default: v = '0;
				endcase
			end
			default: v = $urandom >> $urandom_range(31);
		endcase
		if ($urandom_range(1)) begin
			v = -v;
		end
		return v;
	endfunction

	function automatic radix_t pick_radix();
		radix_t r;
		if ($urandom_range(99) < 15) begin
			case ($urandom_range(2))
				0: r = 6'd0;
				1: r = 6'd1;
				default: r = radix_t'($urandom_range(37, 63));
			endcase
		end else begin
			r = radix_t'($urandom_range(RADIX_MIN, RADIX_MAX));
		end
		return r;
	endfunction

	task automatic test_value_extremes();
		send_item(32'h0000_0000, 6'd10);
		send_item(32'h0000_0000, RADIX_MIN);
		send_item(32'h8000_0000, RADIX_MIN);
		send_item(32'h7fff_ffff, RADIX_MIN);
		send_item(32'h8000_0000, 6'd10);
		send_item(32'h7fff_ffff, 6'd10);
		send_item(32'h7fff_ffff, RADIX_MAX);
		send_item(32'h8000_0000, RADIX_MAX);
		send_item(32'hffff_ffff, 6'd16);
		send_item(32'd35, RADIX_MAX);
		send_item(32'd9, 6'd16);
		send_item(32'd10, 6'd16);
		send_item(32'd255, 6'd16);
		send_item(-32'sd12345, RADIX_MAX);
		send_item(32'd1, 6'd3);
		send_item(-32'sd8, 6'd8);
	endtask

	task automatic test_bad_radix();
		send_item(32'd123, 6'd0);
		send_item(32'hffff_ffff, 6'd1);
		send_item(32'h8000_0000, 6'd37);
		send_item(32'h7fff_ffff, 6'd63);
		send_item(32'd0, 6'd42);
	endtask

	task automatic test_random_stream(int unsigned count, int unsigned tx_pct,
			int unsigned rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (count) send_item(pick_value(), pick_radix());
		hold_until_drained();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 19;
		rx_idle_pct = 62;
		test_value_extremes();
		test_bad_radix();
		hold_until_drained();

		test_random_stream(45, 19, 62);
		test_random_stream(45, 62, 19);
		test_random_stream(50, 0, 0);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_chars.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
